/* hdl/bsc_pkg.sv */
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types, constants and 64-bit product helpers for the barometric
// sensor compensation pipeline.
// ----------------------------------------------------------------------------
package bsc_pkg;

   localparam int DIV_STEPS = 64;

   localparam logic [63:0] TFINE_OFFSET = 64'd128000;
   localparam logic [20:0] PRESS_BASE   = 21'd1048576;
   localparam logic signed [16:0] PRESS_SCALE = 17'sd3125;
   localparam logic [63:0] PRESS_BIAS   = 64'h0000_8000_0000_0000;

   typedef enum logic [1:0] {
      CSR_TEMP_COEF  = 2'd0,
      CSR_PRESS_LOW  = 2'd1,
      CSR_PRESS_HIGH = 2'd2,
      CSR_PRESS_NINE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [15:0]        t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic [15:0]        p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
   } coef_type;

   typedef struct packed {
      logic [31:0] centi;
      logic        dz;
   } side_type;

   typedef struct packed {
      logic [63:0] num;
      logic [63:0] den;
      side_type    side;
   } front_type;

   typedef struct packed {
      logic [63:0] quot;
      side_type    side;
   } quot_type;

   typedef struct packed {
      logic [31:0] centi;
      logic [31:0] press;
      logic        dz;
   } result_type;

   function automatic logic signed [16:0] sx17(input logic [15:0] c);
      return {c[15], c};
   endfunction

   // low 64 bits of x times a 17-bit signed constant, split in two halves
   function automatic logic [63:0] mul64_17(input logic [63:0] x,
                                            input logic signed [16:0] c);
      logic signed [49:0] lo;
      logic [31:0]        hi;
      lo = $signed({1'b0, x[31:0]}) * c;
      hi = x[63:32] * {{15{c[16]}}, c};
      return {{14{lo[49]}}, lo} + {hi, 32'd0};
   endfunction

   // low 64 bits of x squared
   function automatic logic [63:0] sq64(input logic [63:0] x);
      logic [63:0] ll;
      logic [31:0] hl;
      ll = {32'd0, x[31:0]} * {32'd0, x[31:0]};
      hl = x[63:32] * x[31:0];
      return ll + {hl[30:0], 1'b0, 32'd0};
   endfunction

endpackage

/* hdl/baro_sensor_compensation.sv */
// ----------------------------------------------------------------------------
// baro_sensor_compensation
// Integer temperature and pressure compensation of raw barometer samples.
// ----------------------------------------------------------------------------
// Requests enter on req_* (raw temperature and raw pressure sample); each
// request yields one response on rsp_*: temperature in 0.01 degrees,
// pressure in Pa as Q24.8 saturated to 32 bits, and a divide-by-zero flag.
// The user must write calibration words on csr_* (index 0..3) only while no
// request is in flight; the block does not enforce it. csr_ready is always high.
// Most of the pipeline depth is the 64-stage divider, one quotient bit per
// stage. A new request is accepted every cycle while req_stall is low.
// A skid register sits behind the response register. When rsp_stall holds
// a response back, the next result parks in the skid register and then the
// whole pipeline freezes and req_stall rises; nothing is dropped.
// Reset clears all valid bits, the skid flag and the calibration registers.
// ----------------------------------------------------------------------------
module baro_sensor_compensation import bsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [19:0] req_raw_temperature,
   input  logic [19:0] req_raw_pressure,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_temperature_centi,
   output logic [31:0] rsp_pressure_q24_8,
   output logic        rsp_divide_by_zero,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  csr_index_type csr_index,
   input  logic [63:0] csr_wdata
);

   logic [47:0] temp_coef_ff;
   logic [63:0] press_low_ff, press_high_ff;
   logic [15:0] press_nine_ff;
   coef_type    coef;

   logic        en;
   logic        front_valid, div_valid, post_valid;
   front_type   front_data;
   quot_type    div_data;
   result_type  post_data, rsp_ff, skid_ff;
   logic        rsp_valid_ff, full_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coef_ff  <= '0;
         press_low_ff  <= '0;
         press_high_ff <= '0;
         press_nine_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TEMP_COEF:  temp_coef_ff  <= csr_wdata[47:0];
            CSR_PRESS_LOW:  press_low_ff  <= csr_wdata;
            CSR_PRESS_HIGH: press_high_ff <= csr_wdata;
            CSR_PRESS_NINE: press_nine_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      coef.t1 = temp_coef_ff[15:0];
      coef.t2 = temp_coef_ff[31:16];
      coef.t3 = temp_coef_ff[47:32];
      coef.p1 = press_low_ff[15:0];
      coef.p2 = press_low_ff[31:16];
      coef.p3 = press_low_ff[47:32];
      coef.p4 = press_low_ff[63:48];
      coef.p5 = press_high_ff[15:0];
      coef.p6 = press_high_ff[31:16];
      coef.p7 = press_high_ff[47:32];
      coef.p8 = press_high_ff[63:48];
      coef.p9 = press_nine_ff;
   end

   assign en        = !full_ff;
   assign req_stall = full_ff;

   bsc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .raw_t     (req_raw_temperature),
      .raw_p     (req_raw_pressure),
      .coef      (coef),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   bsc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   bsc_post u_post (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid),
      .in_data   (div_data),
      .coef      (coef),
      .out_valid (post_valid),
      .out_data  (post_data)
   );

   // response register with one-entry skid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         full_ff      <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         if (full_ff) begin
            rsp_valid_ff <= 1'b1;
            full_ff      <= 1'b0;
         end else begin
            rsp_valid_ff <= post_valid;
         end
      end else if (post_valid && en) begin
         full_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_ff <= full_ff ? skid_ff : post_data;
      end else if (post_valid && en) begin
         skid_ff <= post_data;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_temperature_centi = rsp_ff.centi;
   assign rsp_pressure_q24_8    = rsp_ff.press;
   assign rsp_divide_by_zero    = rsp_ff.dz;

   a_skid_has_rsp: assert property (@(posedge clock) disable iff (reset)
      full_ff |-> rsp_valid_ff)
      else $error("skid entry held without a pending response");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(full_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid filled while response was not stalled");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_by_zero) |-> (rsp_pressure_q24_8 == 32'd0))
      else $error("divide by zero with nonzero pressure");

endmodule

/* hdl/bsc_front.sv */
// ----------------------------------------------------------------------------
// bsc_front
// Temperature compensation and pressure numerator/divisor preparation.
// ----------------------------------------------------------------------------
module bsc_front import bsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [19:0] raw_t,
   input  logic [19:0] raw_p,
   input  coef_type    coef,
   output logic        out_valid,
   output front_type   out_data
);

   logic [9:0]  vld_ff;
   logic [19:0] rt0_ff, rp0_ff, rp1_ff, rp2_ff, rp3_ff, rp4_ff, rp5_ff, rp6_ff, rp7_ff;
   logic [31:0] a_in, b_in, ta_in, bb_in, ta1_ff, bb1_ff;
   logic [31:0] bbs, tv1_in, tb_in, tv1_ff, tb_ff;
   logic [31:0] fine_in, fine_ff, c5, centi_in;
   logic [31:0] centi4_ff, centi5_ff, centi6_ff, centi7_ff, centi8_ff;
   logic [63:0] v1_in, v1_ff;
   logic [63:0] v1sq_in, v1p5_in, v1p2_in, v1sq_ff, v1p5_ff, v1p2_ff;
   logic [63:0] x6_in, x3_in, x6_ff, x3_ff, v1p5b_ff, v1p2b_ff;
   logic [63:0] p4_64, v2_in, u_in, v2_ff, u_ff;
   logic [20:0] pb;
   logic [63:0] d_in, n0_in, d_ff, n0_ff;
   front_type   out_in, out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[8:0], in_valid};
      end
   end

   assign a_in   = {15'd0, rt0_ff[19:3]} - {15'd0, coef.t1, 1'b0};
   assign b_in   = {16'd0, rt0_ff[19:4]} - {16'd0, coef.t1};
   assign ta_in  = a_in * {{16{coef.t2[15]}}, coef.t2};
   assign bb_in  = b_in * b_in;

   assign tv1_in = 32'($signed(ta1_ff) >>> 11);
   assign bbs    = 32'($signed(bb1_ff) >>> 12);
   assign tb_in  = bbs * {{16{coef.t3[15]}}, coef.t3};

   assign fine_in = tv1_ff + 32'($signed(tb_ff) >>> 14);

   assign c5       = fine_ff + {fine_ff[29:0], 2'b00} + 32'd128;
   assign centi_in = 32'($signed(c5) >>> 8);
   assign v1_in    = {{32{fine_ff[31]}}, fine_ff} - TFINE_OFFSET;

   assign v1sq_in = sq64(v1_ff);
   assign v1p5_in = mul64_17(v1_ff, sx17(coef.p5));
   assign v1p2_in = mul64_17(v1_ff, sx17(coef.p2));

   assign x6_in = mul64_17(v1sq_ff, sx17(coef.p6));
   assign x3_in = mul64_17(v1sq_ff, sx17(coef.p3));

   assign p4_64 = {{48{coef.p4[15]}}, coef.p4};
   assign v2_in = x6_ff + {v1p5b_ff[46:0], 17'd0} + {p4_64[28:0], 35'd0};
   assign u_in  = 64'($signed(x3_ff) >>> 8) + {v1p2b_ff[51:0], 12'd0} + PRESS_BIAS;

   assign pb    = PRESS_BASE - {1'b0, rp7_ff};
   assign d_in  = mul64_17(u_ff, {1'b0, coef.p1});
   assign n0_in = {12'd0, pb, 31'd0} - v2_ff;

   always_comb begin
      out_in.den        = 64'($signed(d_ff) >>> 33);
      out_in.num        = mul64_17(n0_ff, PRESS_SCALE);
      out_in.side.centi = centi8_ff;
      out_in.side.dz    = (out_in.den == 64'd0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rt0_ff    <= raw_t;
         rp0_ff    <= raw_p;
         ta1_ff    <= ta_in;
         bb1_ff    <= bb_in;
         rp1_ff    <= rp0_ff;
         tv1_ff    <= tv1_in;
         tb_ff     <= tb_in;
         rp2_ff    <= rp1_ff;
         fine_ff   <= fine_in;
         rp3_ff    <= rp2_ff;
         v1_ff     <= v1_in;
         centi4_ff <= centi_in;
         rp4_ff    <= rp3_ff;
         v1sq_ff   <= v1sq_in;
         v1p5_ff   <= v1p5_in;
         v1p2_ff   <= v1p2_in;
         centi5_ff <= centi4_ff;
         rp5_ff    <= rp4_ff;
         x6_ff     <= x6_in;
         x3_ff     <= x3_in;
         v1p5b_ff  <= v1p5_ff;
         v1p2b_ff  <= v1p2_ff;
         centi6_ff <= centi5_ff;
         rp6_ff    <= rp5_ff;
         v2_ff     <= v2_in;
         u_ff      <= u_in;
         centi7_ff <= centi6_ff;
         rp7_ff    <= rp6_ff;
         d_ff      <= d_in;
         n0_ff     <= n0_in;
         centi8_ff <= centi7_ff;
         out_ff    <= out_in;
      end
   end

   assign out_valid = vld_ff[9];
   assign out_data  = out_ff;

endmodule

/* hdl/bsc_div.sv */
// ----------------------------------------------------------------------------
// bsc_div
// Pipelined signed divider, 64-bit dividend over the low 32 bits of the divisor magnitude,
// one quotient bit per stage, truncating.
module bsc_div import bsc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      in_valid,
   input  front_type in_data,
   output logic      out_valid,
   output quot_type  out_data
);

   typedef struct packed {
      logic [31:0] rem;
      logic [63:0] nq;
      logic [31:0] mb;
      logic        neg;
      side_type    side;
   } dstep_type;

   logic [DIV_STEPS+1:0] vld_ff;
   dstep_type            stg_ff [0:DIV_STEPS];
   dstep_type            first_in;
   logic [63:0]          den_abs;
   quot_type             out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DIV_STEPS:0], in_valid};
      end
   end

   always_comb begin
      den_abs       = in_data.den[63] ? (64'd0 - in_data.den) : in_data.den;
      first_in.rem  = '0;
      first_in.nq   = in_data.num[63] ? (64'd0 - in_data.num) : in_data.num;
      first_in.mb   = den_abs[31:0];
      first_in.neg  = in_data.num[63] ^ in_data.den[63];
      first_in.side = in_data.side;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stg_ff[0] <= first_in;
      end
   end

   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
      logic [32:0] trial;
      logic        ge;
      dstep_type   nxt;
      always_comb begin
         trial = {stg_ff[k-1].rem, stg_ff[k-1].nq[63]};
         ge    = (trial >= {1'b0, stg_ff[k-1].mb});
         nxt   = stg_ff[k-1];
         nxt.rem = ge ? 32'(trial - {1'b0, stg_ff[k-1].mb}) : trial[31:0];
         nxt.nq  = {stg_ff[k-1].nq[62:0], ge};
      end
      always_ff @(posedge clock) begin
         if (en) begin
            stg_ff[k] <= nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff.quot <= stg_ff[DIV_STEPS].neg ? (64'd0 - stg_ff[DIV_STEPS].nq)
                                              : stg_ff[DIV_STEPS].nq;
         out_ff.side <= stg_ff[DIV_STEPS].side;
      end
   end

   assign out_valid = vld_ff[DIV_STEPS+1];
   assign out_data  = out_ff;

endmodule

/* hdl/bsc_post.sv */
// ----------------------------------------------------------------------------
// bsc_post
// Second-order pressure correction, offset and 32-bit saturation.
// ----------------------------------------------------------------------------
module bsc_post import bsc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  logic       in_valid,
   input  quot_type   in_data,
   input  coef_type   coef,
   output logic       out_valid,
   output result_type out_data
);

   logic [3:0]  vld_ff;
   logic [63:0] q, qq_in, w2_in, qq_ff, w2_ff, p1_ff;
   logic [63:0] w1_in, w2s_in, w1_ff, w2s_ff, p2_ff;
   logic [63:0] s_in, s_ff, p7_64, r;
   side_type    side1_ff, side2_ff, side3_ff;
   result_type  res_in, res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   assign q      = 64'($signed(in_data.quot) >>> 13);
   assign qq_in  = sq64(q);
   assign w2_in  = mul64_17(in_data.quot, sx17(coef.p8));

   assign w1_in  = mul64_17(qq_ff, sx17(coef.p9));
   assign w2s_in = 64'($signed(w2_ff) >>> 19);

   assign s_in   = p2_ff + 64'($signed(w1_ff) >>> 25) + w2s_ff;

   assign p7_64  = {{48{coef.p7[15]}}, coef.p7};
   assign r      = 64'($signed(s_ff) >>> 8) + {p7_64[59:0], 4'd0};

   always_comb begin
      res_in.centi = side3_ff.centi;
      res_in.dz    = side3_ff.dz;
      if (side3_ff.dz || r[63]) begin
         res_in.press = '0;
      end else if (|r[62:32]) begin
         res_in.press = '1;
      end else begin
         res_in.press = r[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qq_ff    <= qq_in;
         w2_ff    <= w2_in;
         p1_ff    <= in_data.quot;
         side1_ff <= in_data.side;
         w1_ff    <= w1_in;
         w2s_ff   <= w2s_in;
         p2_ff    <= p1_ff;
         side2_ff <= side1_ff;
         s_ff     <= s_in;
         side3_ff <= side2_ff;
         res_ff   <= res_in;
      end
   end

   assign out_valid = vld_ff[3];
   assign out_data  = res_ff;

endmodule
